// ----- hdl/asgr_pkg.sv -----
// Shared types, constants and codes for the ANSI SGR dim text filter.
package asgr_pkg;

	// Default parameter count, and the widths of the parameter count and store address.
	localparam int DEF_MAX_PARAMS = 16;
	localparam int PCNT_W         = 7;
	localparam int PADDR_W        = 6;

	// Depth of the command queue between front and back.
	localparam int CMDQ_DEPTH = 4;

	// APB address width: four 32-bit registers.
	localparam int APB_ADDR_W = 4;

	// Byte codes.
	localparam logic [7:0] ESC_BYTE  = 8'h1B;
	localparam logic [7:0] NL_BYTE   = 8'h0A;
	localparam logic [7:0] CSI_OPEN  = 8'h5B;
	localparam logic [7:0] SGR_FINAL = 8'h6D;
	localparam logic [7:0] FINAL_LO  = 8'h40;
	localparam logic [7:0] FINAL_HI  = 8'h7E;
	localparam logic [7:0] SEMI_BYTE = 8'h3B;
	localparam logic [7:0] COLON_BYTE = 8'h3A;
	localparam logic [7:0] DIGIT_0   = 8'h30;
	localparam logic [7:0] DIGIT_9   = 8'h39;

	// Parameter value limit.
	localparam logic [9:0] NUM_MAX = 10'd1023;

	// SGR codes.
	localparam logic [9:0] SGR_RESET      = 10'd0;
	localparam logic [9:0] SGR_DIM        = 10'd2;
	localparam logic [9:0] SGR_NORMAL     = 10'd22;
	localparam logic [9:0] SGR_FG_EXT     = 10'd38;
	localparam logic [9:0] SGR_FG_DEFAULT = 10'd39;
	localparam logic [9:0] SEL_PALETTE    = 10'd5;
	localparam logic [9:0] SEL_RGB        = 10'd2;

	// Register reset values.
	localparam logic [7:0] DEF_GREY_LOW    = 8'd232;
	localparam logic [7:0] DEF_GREY_HIGH   = 8'd243;
	localparam logic [7:0] DEF_DARK_MAX    = 8'd120;
	localparam logic [7:0] DEF_SPREAD_MAX  = 8'd20;

	typedef enum logic [1:0] {
		REG_GREY_LOW   = 2'd0,
		REG_GREY_HIGH  = 2'd1,
		REG_DARK_MAX   = 2'd2,
		REG_SPREAD_MAX = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       last;
	} item_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       dim;
		logic       byte_valid;
		logic       end_of_string;
	} result_t;

	typedef struct packed {
		logic [7:0] grey_index_low;
		logic [7:0] grey_index_high;
		logic [7:0] dark_channel_max;
		logic [7:0] grey_spread_max;
	} cfg_t;

	// Command from the front part to the back part.
	typedef struct packed {
		logic              is_sgr;
		logic              esc_first;
		logic              has_byte;
		logic [7:0]        data;
		logic              eos;
		logic [PCNT_W-1:0] count;
	} cmd_t;

	// Parameter store write.
	typedef struct packed {
		logic               en;
		logic [PADDR_W-1:0] addr;
		logic [9:0]         data;
	} pwr_t;

endpackage

// ----- hdl/asgr_front.sv -----
// Front part: parses the byte stream, collects CSI parameters and issues commands.
module asgr_front import asgr_pkg::*; #(
	parameter int MAX_PARAMS = DEF_MAX_PARAMS
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	output logic  full,
	input  item_t item,
	input  logic  q_full,
	output logic  q_push,
	output cmd_t  q_cmd,
	output pwr_t  pwr,
	input  logic  walk_done
);

	localparam int CW = $clog2(MAX_PARAMS + 1);

	typedef enum logic [1:0] {
		M_TEXT,
		M_HELD,
		M_CSI
	} mode_t;

	mode_t         mode_q;
	logic [9:0]    cur_q;
	logic          seen_q;
	logic [CW-1:0] cnt_q;
	logic          sgr_pend_q;

	logic          accept;
	logic [7:0]    b;
	logic          is_final;
	logic          is_sep;
	logic          is_digit;
	logic          has_room;
	logic [CW-1:0] cnt_push;
	logic [13:0]   acc;
	logic [9:0]    cur_n;
	logic          need_cmd;

	assign b        = item.in_byte;
	assign is_final = (b >= FINAL_LO) && (b <= FINAL_HI);
	assign is_sep   = (b == SEMI_BYTE) || (b == COLON_BYTE);
	assign is_digit = (b >= DIGIT_0) && (b <= DIGIT_9);
	assign has_room = cnt_q < CW'(MAX_PARAMS);
	assign cnt_push = has_room ? cnt_q + CW'(1) : cnt_q;

	assign acc   = ({4'b0, cur_q} << 3) + ({4'b0, cur_q} << 1) + {6'b0, b - DIGIT_0};
	assign cur_n = (acc > {4'b0, NUM_MAX}) ? NUM_MAX : acc[9:0];

	// CSI bytes must not touch the parameter store while a walk is pending.
	assign full   = q_full || (sgr_pend_q && (mode_q != M_TEXT));
	assign accept = push && !full;

	assign pwr.en   = accept && (mode_q == M_CSI) && (is_final || is_sep) && has_room;
	assign pwr.addr = PADDR_W'(cnt_q);
	assign pwr.data = seen_q ? cur_q : 10'd0;

	always_comb begin
		q_cmd           = '0;
		q_cmd.data      = b;
		q_cmd.eos       = item.last;
		q_cmd.count     = PCNT_W'(cnt_push);
		case (mode_q)
			M_CSI: begin
				q_cmd.is_sgr = (b == SGR_FINAL) && !item.last;
			end
			M_HELD: begin
				if (b != CSI_OPEN) begin
					q_cmd.esc_first = 1'b1;
					q_cmd.has_byte  = !((b == ESC_BYTE) && !item.last);
				end
			end
			M_TEXT: begin
				q_cmd.has_byte = !((b == ESC_BYTE) && !item.last);
			end
			default: begin
				q_cmd.has_byte = 1'b0;
			end
		endcase
	end

	assign need_cmd = q_cmd.is_sgr || q_cmd.esc_first || q_cmd.has_byte || q_cmd.eos;
	assign q_push   = accept && need_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= M_TEXT;
			cur_q      <= '0;
			seen_q     <= 1'b0;
			cnt_q      <= '0;
			sgr_pend_q <= 1'b0;
		end else begin
			if (walk_done) begin
				sgr_pend_q <= 1'b0;
			end
			if (accept) begin
				if (q_cmd.is_sgr) begin
					sgr_pend_q <= 1'b1;
				end
				if (item.last) begin
					mode_q <= M_TEXT;
					cur_q  <= '0;
					seen_q <= 1'b0;
					cnt_q  <= '0;
				end else begin
					case (mode_q)
						M_CSI: begin
							if (is_final || is_sep) begin
								if (is_final) begin
									mode_q <= M_TEXT;
								end
								cnt_q  <= cnt_push;
								cur_q  <= '0;
								seen_q <= 1'b0;
							end else if (is_digit) begin
								cur_q  <= cur_n;
								seen_q <= 1'b1;
							end
						end
						M_HELD: begin
							if (b == CSI_OPEN) begin
								mode_q <= M_CSI;
								cnt_q  <= '0;
								cur_q  <= '0;
								seen_q <= 1'b0;
							end else if (b == ESC_BYTE) begin
								mode_q <= M_HELD;
							end else begin
								mode_q <= M_TEXT;
							end
						end
						M_TEXT: begin
							if (b == ESC_BYTE) begin
								mode_q <= M_HELD;
							end
						end
						default: begin
							mode_q <= M_TEXT;
						end
					endcase
				end
			end
		end
	end

endmodule

// ----- hdl/asgr_cmdq.sv -----
// Short command queue between the front and back parts.
module asgr_cmdq import asgr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t din,
	output logic full,
	input  logic pop,
	output cmd_t dout,
	output logic empty
);

	localparam int PW = $clog2(CMDQ_DEPTH);
	localparam int NW = $clog2(CMDQ_DEPTH + 1);

	cmd_t          ent_q [CMDQ_DEPTH];
	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic [NW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full    = cnt_q == NW'(CMDQ_DEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wp_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= (wp_q == PW'(CMDQ_DEPTH - 1)) ? '0 : wp_q + PW'(1);
			end
			if (do_pop) begin
				rp_q <= (rp_q == PW'(CMDQ_DEPTH - 1)) ? '0 : rp_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + NW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - NW'(1);
			end
		end
	end

endmodule

// ----- hdl/asgr_back.sv -----
// Back part: holds the dim state, walks SGR parameters and drives the result beats.
module asgr_back import asgr_pkg::*; #(
	parameter int MAX_PARAMS = DEF_MAX_PARAMS
) (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    cmd_valid,
	input  cmd_t    cmd,
	output logic    cmd_pop,
	input  pwr_t    pwr,
	output logic    walk_done,
	output result_t result,
	output logic    empty,
	input  logic    pop
);

	localparam int AW = $clog2(MAX_PARAMS);
	localparam int CW = $clog2(MAX_PARAMS + 1);
	localparam int XW = CW + 3;

	typedef enum logic [1:0] {
		B_IDLE,
		B_BYTE,
		B_WALK
	} bstate_t;

	typedef enum logic [2:0] {
		IM_CODE,
		IM_SEL,
		IM_IDX,
		IM_R,
		IM_G,
		IM_B
	} imode_t;

	logic [9:0] mem [MAX_PARAMS];
	logic [9:0] rd_data_s1;

	bstate_t       st_q;
	imode_t        im_q;
	result_t       out_q;
	logic          out_v_q;
	logic          attr_q;
	logic          color_q;
	logic [7:0]    hold_byte_q;
	logic          hold_eos_q;
	logic [CW-1:0] n_q;
	logic [CW-1:0] rd_ptr_q;
	logic          dv_s1;
	logic [CW-1:0] dpos_s1;
	logic [9:0]    hi_q;
	logic [9:0]    lo_q;

	logic    dim_now;
	logic    out_free;
	logic    load;
	result_t ld_res;
	logic    clr;
	logic    go_byte;
	logic    go_walk;
	logic    walk_step;

	logic       attr_w;
	logic       color_w;
	imode_t     im_w;
	logic [9:0] hi_w;
	logic [9:0] lo_w;
	logic [9:0] v;
	logic       as_code;
	logic       p1lt;
	logic       p3lt;
	logic [9:0] hi3;
	logic [9:0] lo3;

	always_ff @(posedge clk) begin
		if (pwr.en) begin
			mem[pwr.addr[AW-1:0]] <= pwr.data;
		end
		rd_data_s1 <= mem[rd_ptr_q[AW-1:0]];
	end

	assign result   = out_q;
	assign empty    = !out_v_q;
	assign out_free = !out_v_q || pop;
	assign dim_now  = attr_q || color_q;

	assign walk_step = (st_q == B_WALK) && dv_s1;
	assign walk_done = walk_step && (dpos_s1 == n_q - CW'(1));

	// Emission of text beats and end markers, and the start of SGR parameter walks.
	always_comb begin
		load    = 1'b0;
		ld_res  = '0;
		cmd_pop = 1'b0;
		clr     = 1'b0;
		go_byte = 1'b0;
		go_walk = 1'b0;
		case (st_q)
			B_IDLE: begin
				if (cmd_valid) begin
					if (cmd.is_sgr) begin
						cmd_pop = 1'b1;
						go_walk = 1'b1;
					end else if (out_free) begin
						cmd_pop = 1'b1;
						load    = 1'b1;
						if (cmd.esc_first) begin
							ld_res.text_byte     = ESC_BYTE;
							ld_res.dim           = dim_now;
							ld_res.byte_valid    = 1'b1;
							ld_res.end_of_string = cmd.eos && !cmd.has_byte;
							go_byte              = cmd.has_byte;
							clr                  = cmd.eos && !cmd.has_byte;
						end else if (cmd.has_byte) begin
							ld_res.text_byte     = cmd.data;
							ld_res.dim           = (cmd.data == NL_BYTE) ? 1'b0 : dim_now;
							ld_res.byte_valid    = 1'b1;
							ld_res.end_of_string = cmd.eos;
							clr                  = cmd.eos;
						end else begin
							ld_res.end_of_string = cmd.eos;
							clr                  = cmd.eos;
						end
					end
				end
			end
			B_BYTE: begin
				if (out_free) begin
					load                 = 1'b1;
					ld_res.text_byte     = hold_byte_q;
					ld_res.dim           = (hold_byte_q == NL_BYTE) ? 1'b0 : dim_now;
					ld_res.byte_valid    = 1'b1;
					ld_res.end_of_string = hold_eos_q;
					clr                  = hold_eos_q;
				end
			end
			default: begin
				load = 1'b0;
			end
		endcase
	end

	// One stored parameter is interpreted per cycle; 38 sub-arguments follow in order.
	always_comb begin
		v       = rd_data_s1;
		attr_w  = attr_q;
		color_w = color_q;
		im_w    = im_q;
		hi_w    = hi_q;
		lo_w    = lo_q;
		as_code = 1'b0;
		p1lt    = ({3'b0, dpos_s1} + XW'(1)) < {3'b0, n_q};
		p3lt    = ({3'b0, dpos_s1} + XW'(3)) < {3'b0, n_q};
		hi3     = (v > hi_q) ? v : hi_q;
		lo3     = (v < lo_q) ? v : lo_q;
		case (im_q)
			IM_CODE: begin
				as_code = 1'b1;
			end
			IM_SEL: begin
				if ((v == SEL_PALETTE) && p1lt) begin
					im_w = IM_IDX;
				end else if ((v == SEL_RGB) && p3lt) begin
					im_w = IM_R;
				end else begin
					as_code = 1'b1;
				end
			end
			IM_IDX: begin
				color_w = (v >= {2'b0, cfg.grey_index_low}) && (v <= {2'b0, cfg.grey_index_high});
				im_w    = IM_CODE;
			end
			IM_R: begin
				hi_w = v;
				lo_w = v;
				im_w = IM_G;
			end
			IM_G: begin
				hi_w = hi3;
				lo_w = lo3;
				im_w = IM_B;
			end
			IM_B: begin
				color_w = (hi3 <= {2'b0, cfg.dark_channel_max})
					&& ((hi3 - lo3) <= {2'b0, cfg.grey_spread_max});
				im_w    = IM_CODE;
			end
			default: begin
				im_w = IM_CODE;
			end
		endcase
		if (as_code) begin
			im_w = IM_CODE;
			case (v)
				SGR_RESET: begin
					attr_w  = 1'b0;
					color_w = 1'b0;
				end
				SGR_DIM: begin
					attr_w = 1'b1;
				end
				SGR_NORMAL: begin
					attr_w = 1'b0;
				end
				SGR_FG_DEFAULT: begin
					color_w = 1'b0;
				end
				SGR_FG_EXT: begin
					if (p1lt) begin
						im_w = IM_SEL;
					end
				end
				default: begin
					im_w = IM_CODE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= B_IDLE;
			im_q     <= IM_CODE;
			out_v_q  <= 1'b0;
			attr_q   <= 1'b0;
			color_q  <= 1'b0;
			n_q      <= '0;
			rd_ptr_q <= '0;
			dv_s1    <= 1'b0;
			dpos_s1  <= '0;
		end else begin
			if (load) begin
				out_q   <= ld_res;
				out_v_q <= 1'b1;
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
			if (clr) begin
				attr_q  <= 1'b0;
				color_q <= 1'b0;
			end else if (walk_step) begin
				attr_q  <= attr_w;
				color_q <= color_w;
				im_q    <= im_w;
				hi_q    <= hi_w;
				lo_q    <= lo_w;
			end
			case (st_q)
				B_IDLE: begin
					if (go_walk) begin
						st_q     <= B_WALK;
						n_q      <= cmd.count[CW-1:0];
						rd_ptr_q <= '0;
						dv_s1    <= 1'b0;
						im_q     <= IM_CODE;
					end else if (go_byte) begin
						st_q        <= B_BYTE;
						hold_byte_q <= cmd.data;
						hold_eos_q  <= cmd.eos;
					end
				end
				B_BYTE: begin
					if (load) begin
						st_q <= B_IDLE;
					end
				end
				B_WALK: begin
					// The read pointer has reached the count by the last step, so the
					// valid bit drops through the else arm.
					if (rd_ptr_q < n_q) begin
						rd_ptr_q <= rd_ptr_q + CW'(1);
						dv_s1    <= 1'b1;
						dpos_s1  <= rd_ptr_q;
					end else begin
						dv_s1 <= 1'b0;
					end
					if (walk_done) begin
						st_q <= B_IDLE;
					end
				end
				default: begin
					st_q <= B_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- hdl/ansi_sgr_dim_text_filter_unit.sv -----
// A text byte is registered in the command queue and then in the result register on its way to the result ports.
// Throughput: one text byte per cycle unless stalled by back-pressure or an SGR walk; an ESC followed by a byte
// other than '[' or a non-final ESC yields two beats. An SGR final 'm' occupies the back part while it walks its
// stored parameters, one parameter store read per cycle; a following '[' waits until that walk is done.
// Reset (arst_n low) returns the parser to text mode with dim clear, empties the
// queues and loads the registers with their defaults; no clearing pass is needed.
module ansi_sgr_dim_text_filter_unit import asgr_pkg::*; #(
	parameter int MAX_PARAMS = DEF_MAX_PARAMS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  item_t                 item,
	output logic                  empty,
	input  logic                  pop,
	output result_t               result,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	cfg_t     cfg_q;
	reg_idx_t ridx;
	logic     wr_en;

	cmd_t q_din;
	cmd_t q_dout;
	logic q_push;
	logic q_pop;
	logic q_full;
	logic q_empty;
	pwr_t pwr;
	logic walk_done;

	assign pready = 1'b1;
	assign ridx   = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grey_index_low   <= DEF_GREY_LOW;
			cfg_q.grey_index_high  <= DEF_GREY_HIGH;
			cfg_q.dark_channel_max <= DEF_DARK_MAX;
			cfg_q.grey_spread_max  <= DEF_SPREAD_MAX;
		end else if (wr_en) begin
			case (ridx)
				REG_GREY_LOW:   cfg_q.grey_index_low   <= pwdata[7:0];
				REG_GREY_HIGH:  cfg_q.grey_index_high  <= pwdata[7:0];
				REG_DARK_MAX:   cfg_q.dark_channel_max <= pwdata[7:0];
				REG_SPREAD_MAX: cfg_q.grey_spread_max  <= pwdata[7:0];
				default:        cfg_q                  <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (ridx)
			REG_GREY_LOW:   prdata = {24'b0, cfg_q.grey_index_low};
			REG_GREY_HIGH:  prdata = {24'b0, cfg_q.grey_index_high};
			REG_DARK_MAX:   prdata = {24'b0, cfg_q.dark_channel_max};
			REG_SPREAD_MAX: prdata = {24'b0, cfg_q.grey_spread_max};
			default:        prdata = '0;
		endcase
	end

	asgr_front #(
		.MAX_PARAMS(MAX_PARAMS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (q_din),
		.pwr      (pwr),
		.walk_done(walk_done)
	);

	asgr_cmdq u_cmdq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.din   (q_din),
		.full  (q_full),
		.pop   (q_pop),
		.dout  (q_dout),
		.empty (q_empty)
	);

	asgr_back #(
		.MAX_PARAMS(MAX_PARAMS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.cmd_valid(!q_empty),
		.cmd      (q_dout),
		.cmd_pop  (q_pop),
		.pwr      (pwr),
		.walk_done(walk_done),
		.result   (result),
		.empty    (empty),
		.pop      (pop)
	);

endmodule
